// ===== sv/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

    // Word width of modulus, exponent, ciphertext and plaintext
    localparam int WIDTH = 16;
    // Counter widths derived from the word width
    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam int BIT_W = $clog2(WIDTH);
    // Config register index width
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [WIDTH-1:0] MODULUS_RESET  = WIDTH'(323);
    localparam logic [WIDTH-1:0] EXPONENT_RESET = WIDTH'(107);

    // Config register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS  = 2'd0,
        REG_EXPONENT = 2'd1
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT
    } mexp_state_t;

    // Multiplier launch bundle
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
    } mul_req_t;

    // Multiplier status bundle
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] res;
    } mul_rsp_t;

endpackage

// ===== sv/mexp_cfg.sv =====
// Configuration registers: modulus and exponent.
module mexp_cfg
    import mexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data,
    output logic [WIDTH-1:0]     modulus,
    output logic [WIDTH-1:0]     exponent
);

    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] modulus_next;
    logic [WIDTH-1:0] exponent_reg;
    logic [WIDTH-1:0] exponent_next;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODULUS:  modulus_next  = cfg_data;
                REG_EXPONENT: exponent_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            exponent_reg <= EXPONENT_RESET;
        end
        else
        begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    assign modulus  = modulus_reg;
    assign exponent = exponent_reg;

endmodule

// ===== sv/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: res = x * y mod n, y < n.
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mul_req_t         req,
    input  logic [WIDTH-1:0] n,
    output mul_rsp_t         rsp
);

    logic             active_reg;
    logic             active_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] y_reg;
    logic [WIDTH-1:0] r_reg;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] n1;
    logic [WIDTH+1:0] n2;
    logic [WIDTH+1:0] red;

    // One step: r = (2r + bit*y) mod n, sum stays below 3n
    always_comb
    begin
        n1  = {2'b00, n};
        n2  = {1'b0, n, 1'b0};
        sum = {1'b0, r_reg, 1'b0} + (x_reg[WIDTH-1] ? {2'b00, y_reg} : '0);
        if (sum >= n2)
            red = sum - n2;
        else if (sum >= n1)
            red = sum - n1;
        else
            red = sum;
    end

    // Step counter control
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(WIDTH);
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
            r_reg <= '0;
        end
        else if (active_reg)
        begin
            x_reg <= {x_reg[WIDTH-2:0], 1'b0};
            r_reg <= red[WIDTH-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = r_reg;

endmodule

// ===== sv/modular_exponentiation.sv =====
// Top level: square-and-multiply sequencer around a shared modular multiplier.
//
//  channel  | signals                                | handshake
//  ---------+----------------------------------------+---------------------------
//  request  | start, busy, ciphertext                | taken when start && !busy
//  result   | done, plaintext                        | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, data  | written when valid && ready
//
// One request runs a base reduction, then a square for every exponent bit and
// a multiply for every set bit, all on the bit-serial multiplier, one bit of
// x per cycle, which the base reduction, multiplies and squares share.
// busy is high from acceptance until the result strobe; results cannot be
// held off. Reset restores modulus 323 and exponent 107.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WIDTH-1:0]     ciphertext,
    output logic                 done,
    output logic [WIDTH-1:0]     plaintext,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data
);

    mexp_state_t      state_reg;
    mexp_state_t      state_next;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] sq_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [BIT_W-1:0] bit_cnt_reg;
    logic [WIDTH-1:0] plaintext_reg;
    logic             done_reg;
    logic             done_next;

    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] one_mod;
    logic             accept;
    logic             last_bit;
    mul_req_t         mul_req;
    mul_rsp_t         mul_rsp;

    assign cfg_ready = 1'b1;

    mexp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .modulus   (modulus),
        .exponent  (exponent)
    );

    mexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .n     (modulus),
        .rsp   (mul_rsp)
    );

    assign accept   = start && (state_reg == ST_IDLE);
    assign last_bit = (bit_cnt_reg == BIT_W'(WIDTH - 1));
    // 1 mod n: zero only for a modulus of one
    assign one_mod  = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_RED_GO;
            ST_RED_GO:
                state_next = ST_RED_WAIT;
            ST_RED_WAIT:
                if (mul_rsp.done)
                    state_next = exp_reg[0] ? ST_ACC_GO : ST_SQ_GO;
            ST_ACC_GO:
                state_next = ST_ACC_WAIT;
            ST_ACC_WAIT:
                if (mul_rsp.done)
                    state_next = ST_SQ_GO;
            ST_SQ_GO:
                state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:
                if (mul_rsp.done)
                begin
                    if (last_bit)
                        state_next = ST_IDLE;
                    else
                        state_next = exp_reg[1] ? ST_ACC_GO : ST_SQ_GO;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs: multiplier launch, operand selection and the result strobe
    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.x     = sq_reg;
        mul_req.y     = sq_reg;
        done_next     = 1'b0;
        unique case (state_reg)
            ST_RED_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.y     = one_mod;
            end
            ST_ACC_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.x     = acc_reg;
            end
            ST_SQ_GO:
                mul_req.start = 1'b1;
            ST_SQ_WAIT:
                done_next = mul_rsp.done && last_bit;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (accept)
                bit_cnt_reg <= '0;
            else if (state_reg == ST_SQ_WAIT && mul_rsp.done)
                bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg  <= ciphertext;
            acc_reg <= one_mod;
            exp_reg <= exponent;
        end
        else if (mul_rsp.done)
        begin
            unique case (state_reg)
                ST_RED_WAIT:
                    sq_reg <= mul_rsp.res;
                ST_ACC_WAIT:
                    acc_reg <= mul_rsp.res;
                ST_SQ_WAIT:
                begin
                    sq_reg  <= mul_rsp.res;
                    exp_reg <= {1'b0, exp_reg[WIDTH-1:1]};
                end
                default:
                    ;
            endcase
        end
        // Capture result; a zero modulus gives zero
        if (done_next)
            plaintext_reg <= (modulus == '0) ? '0 : acc_reg;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign plaintext = plaintext_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the square-and-multiply modular exponentiation block.
`timescale 1ns / 100ps

module tb_top;
    import mexp_pkg::*;

    // Run limits
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 700;
    localparam int RANDOM_ITEMS  = 630;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [WIDTH-1:0]     ciphertext;
    logic                 done;
    logic [WIDTH-1:0]     plaintext;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDTH-1:0]     cfg_data;

    // Shadow of the block's registers and the plaintexts still owed
    logic [WIDTH-1:0] cur_modulus;
    logic [WIDTH-1:0] cur_exponent;
    logic [WIDTH-1:0] expected_plain[$];
    logic [WIDTH-1:0] want_plain;

    int n_requests  = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_settings  = 0;
    int idle_cycles = 0;

    modular_exponentiation u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .ciphertext (ciphertext),
        .done       (done),
        .plaintext  (plaintext),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // base^e mod n, right-to-left over all WIDTH exponent bits
    function automatic logic [WIDTH-1:0] pow_mod(input logic [WIDTH-1:0] base,
                                                 input logic [WIDTH-1:0] e,
                                                 input logic [WIDTH-1:0] n);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] nn;
        if (n == '0)
            return '0;
        nn  = 64'(n);
        acc = 64'd1 % nn;
        sq  = 64'(base) % nn;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (e[i])
                acc = (acc * sq) % nn;
            sq = (sq * sq) % nn;
        end
        return acc[WIDTH-1:0];
    endfunction

    // Send one request; start stays high when the next one follows at once
    task automatic send_word(input logic [WIDTH-1:0] word, input int gap);
        start      <= 1'b1;
        ciphertext <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_plain.push_back(pow_mod(word, cur_exponent, cur_modulus));
        n_requests++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every owed plaintext has come back
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_plain.size() != 0)
            @(posedge clk);
    endtask

    // One register write; valid stays high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MODULUS)
            cur_modulus = value;
        else if (idx == REG_EXPONENT)
            cur_exponent = value;
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
    endtask

    task automatic set_key(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] e);
        wait_idle();
        write_reg(REG_MODULUS, n);
        write_reg(REG_EXPONENT, e);
        close_cfg();
        n_settings++;
    endtask

    // Random base: extremes, values around the modulus, full range
    function automatic logic [WIDTH-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WIDTH'($urandom_range(0, int'(cur_modulus) - 1));
            3: return cur_modulus;
            default: return WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_modulus();
        case ($urandom_range(0, 7))
            0: return WIDTH'(1);
            1: return '1;
            2: return WIDTH'(2);
            3: return WIDTH'($urandom_range(2, 255));
            default: return WIDTH'($urandom_range(1, (1 << WIDTH) - 1));
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WIDTH'(1);
            3: return WIDTH'($urandom_range(0, 255));
            default: return WIDTH'($urandom);
        endcase
    endfunction

    // Reset key 323 / 107 with edge-case bases
    task automatic test_reset_key();
        send_word(WIDTH'(0), 0);
        send_word(WIDTH'(1), 0);
        send_word(WIDTH'(2), 3);
        send_word(WIDTH'(322), 0);
        send_word(WIDTH'(323), 1);
        send_word(WIDTH'(324), 0);
        send_word(WIDTH'(16'hAAAA), 0);
        send_word(WIDTH'(16'h5555), 2);
        send_word('1, 0);
    endtask

    // Register extremes: full-width key, modulus one, exponent zero and one
    task automatic test_extreme_keys();
        set_key('1, '1);
        send_word('0, 0);
        send_word('1, 0);
        send_word(WIDTH'(65534), 0);
        send_word(WIDTH'(12345), 0);
        set_key(WIDTH'(1), WIDTH'(16'hBEEF));
        send_word(WIDTH'(7), 0);
        send_word('1, 0);
        set_key('1, '0);
        send_word('0, 0);
        send_word('1, 0);
        set_key(WIDTH'(1), '0);
        send_word(WIDTH'(1), 0);
        set_key(WIDTH'(40000), WIDTH'(1));
        send_word('1, 0);
        send_word(WIDTH'(39999), 0);
        set_key(WIDTH'(2), '1);
        send_word(WIDTH'(3), 0);
    endtask

    // Writes to undecoded indexes must leave the key alone
    task automatic test_spare_index();
        wait_idle();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, WIDTH'(1));
        close_cfg();
        send_word(WIDTH'(16'h1234), 0);
        send_word('1, 0);
    endtask

    // Random keys, bursts of requests, short and long sender gaps
    task automatic test_random_traffic();
        int left;
        int phase_items;
        int burst;
        int gap;
        bit no_idle;
        left = RANDOM_ITEMS;
        while (left > 0)
        begin
            wait_idle();
            if ($urandom_range(0, 4) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, WIDTH'($urandom));
            end
            case ($urandom_range(0, 3))
                0: write_reg(REG_MODULUS, pick_modulus());
                1: write_reg(REG_EXPONENT, pick_exponent());
                default:
                begin
                    write_reg(REG_MODULUS, pick_modulus());
                    write_reg(REG_EXPONENT, pick_exponent());
                end
            endcase
            close_cfg();
            n_settings++;
            phase_items = $urandom_range(20, 60);
            no_idle     = ($urandom_range(0, 3) == 0);
            while (phase_items > 0 && left > 0)
            begin
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst && phase_items > 0 && left > 0; i++)
                begin
                    gap = 0;
                    if (!no_idle && (i == burst - 1))
                        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 700)
                                                          : $urandom_range(1, 12);
                    send_word(pick_word(), gap);
                    phase_items--;
                    left--;
                end
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_plain.size() == 0)
            begin
                $display("%0t: plaintext %0d with no request waiting", $time, plaintext);
                n_errors++;
            end
            else
            begin
                want_plain = expected_plain.pop_front();
                n_checked++;
                if (plaintext !== want_plain)
                begin
                    $display("%0t: plaintext mismatch, expected %0d, actual %0d",
                             $time, want_plain, plaintext);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        ciphertext   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_MODULUS;
        cfg_data     = '0;
        cur_modulus  = MODULUS_RESET;
        cur_exponent = EXPONENT_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_key();
        test_extreme_keys();
        test_spare_index();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_plain.size() != 0)
        begin
            $display("%0t: %0d plaintexts never arrived", $time, expected_plain.size());
            n_errors++;
        end

        $display("Sent %0d requests under %0d key settings; %0d results checked, %0d errors",
                 n_requests, n_settings, n_checked, n_errors);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mexp_pkg.sv
sv/mexp_cfg.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation.sv
tb/tb_top.sv
